// ===== rtl/core/burst_fire_heater_supervisor_macros.svh =====
// Assertion macros for the burst-fire heater supervisor.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BURST_FIRE_HEATER_SUPERVISOR_MACROS_SVH
`define BURST_FIRE_HEATER_SUPERVISOR_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define BFHS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("BFHS check failed");

// Checks that cons holds in the cycle after ante.
`define BFHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("BFHS check failed");

`endif

// ===== rtl/core/bfhs_pkg.sv =====
// Shared types and constants of the burst-fire heater supervisor.
// Used by every module of the block.
`default_nettype none

package bfhs_pkg;

  localparam int unsigned CntW = 16;

  localparam logic [7:0] MAX_POWER    = 8'd100;
  localparam logic [7:0] MARGIN_RESET = 8'd10;

  typedef enum logic [1:0] {
    REQ_CROSS    = 2'd0,
    REQ_FEEDBACK = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_POWER    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_PHASE = 2'd1,
    FAULT_OPEN  = 2'd2,
    FAULT_STUCK = 2'd3
  } fault_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] power;
  } req_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

`default_nettype wire

// ===== rtl/core/bfhs_req_if.sv =====
// Request channel of the heater supervisor: one event item per handshake.
// Standalone; no package dependency.
`default_nettype none

interface bfhs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] power;

  modport source(output valid, output req_type, output power, input ready);
  modport sink(input valid, input req_type, input power, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfhs_rsp_if.sv =====
// Result channel of the heater supervisor: one result item per event.
// Standalone; no package dependency.
`default_nettype none

interface bfhs_rsp_if;
  logic       valid;
  logic       ready;
  logic       relay_on;
  logic       cycle_end;
  logic [1:0] fault_code;
  logic       fault_new;

  modport source(output valid, output relay_on, output cycle_end, output fault_code,
                 output fault_new, input ready);
  modport sink(input valid, input relay_on, input cycle_end, input fault_code,
               input fault_new, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfhs_cfg_if.sv =====
// Configuration write channel carrying the fault margin register.
// Standalone; no package dependency.
`default_nettype none

interface bfhs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfhs_in_reg.sv =====
// Input register stage that captures one event item per cycle unless the engine stalls it.
// Depends on bfhs_pkg and bfhs_req_if.
`default_nettype none

module bfhs_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  bfhs_req_if.sink        req_i,
  output bfhs_pkg::hs_t   item_hs_o,
  input  logic            item_ready_i,
  output bfhs_pkg::req_t  item_o
);
  import bfhs_pkg::*;

  logic valid_q, valid_d;
  req_t item_q;
  logic accept;

  assign req_i.ready = !valid_q || item_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{req_type: req_i.req_type, power: req_i.power};
    end
  end

  assign item_hs_o = '{valid: valid_q, ready: item_ready_i};
  assign item_o    = item_q;
endmodule

`default_nettype wire

// ===== rtl/core/bfhs_engine.sv =====
// Supervisor state, per-event update logic and the result register.
// Depends on bfhs_pkg, bfhs_rsp_if and bfhs_cfg_if.
`default_nettype none

module bfhs_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  bfhs_pkg::req_t  item_i,
  bfhs_cfg_if.sink        cfg_i,
  bfhs_rsp_if.source      rsp_o
);
  import bfhs_pkg::*;

  logic [7:0]      phase_q, phase_d;
  logic [CntW-1:0] cross_q, cross_d;
  logic [CntW-1:0] off_q, off_d;
  logic [CntW-1:0] fb_q, fb_d;
  logic [7:0]      power_q, power_d;
  logic            relay_q, relay_d;
  fault_e          fault_q, fault_d;
  logic [7:0]      margin_q;

  logic            rsp_valid_q, rsp_valid_d;
  logic            cyc_end, fresh;
  logic            fire;
  logic [CntW-1:0] diff_of, diff_fo;
  logic [CntW-1:0] margin_ext;
  logic            open_hit, stuck_hit;

  logic            relay_on_q, cycle_end_q, fault_new_q;
  logic [1:0]      fault_code_q;

  assign item_ready_o = !rsp_valid_q || rsp_o.ready;
  assign fire         = item_valid_i && item_ready_o;
  assign cfg_i.ready  = 1'b1;

  assign margin_ext = {{(CntW - 8){1'b0}}, margin_q};
  assign diff_of    = off_q - fb_q;
  assign diff_fo    = fb_q - off_q;
  assign open_hit   = !diff_of[CntW-1] && (diff_of > margin_ext);
  assign stuck_hit  = !diff_fo[CntW-1] && (diff_fo > margin_ext);

  always_comb begin
    phase_d = phase_q;
    cross_d = cross_q;
    off_d   = off_q;
    fb_d    = fb_q;
    power_d = power_q;
    relay_d = relay_q;
    fault_d = fault_q;
    cyc_end = 1'b0;
    fresh   = 1'b0;
    if (fault_q == FAULT_NONE) begin
      case (req_e'(item_i.req_type))
        REQ_CROSS: begin
          cross_d = cross_q + 1'b1;
          phase_d = phase_q + 1'b1;
          if (phase_q < power_q) begin
            relay_d = 1'b1;
          end else begin
            relay_d = 1'b0;
            off_d   = off_q + 1'b1;
            if (phase_q >= MAX_POWER) begin
              phase_d = 8'd1;
              cyc_end = 1'b1;
            end
          end
        end
        REQ_FEEDBACK: begin
          fb_d = fb_q + 1'b1;
        end
        REQ_TICK: begin
          if (cross_q == '0) begin
            fault_d = FAULT_PHASE;
            fresh   = 1'b1;
          end else begin
            if (open_hit) begin
              fault_d = FAULT_OPEN;
              fresh   = 1'b1;
            end else if (stuck_hit) begin
              fault_d = FAULT_STUCK;
              fresh   = 1'b1;
            end
            cross_d = '0;
            off_d   = '0;
            fb_d    = '0;
          end
          if (fresh) begin
            power_d = '0;
            relay_d = 1'b0;
          end
        end
        REQ_POWER: begin
          if (item_i.power <= MAX_POWER) begin
            power_d = item_i.power;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      cross_q     <= '0;
      off_q       <= '0;
      fb_q        <= '0;
      power_q     <= '0;
      relay_q     <= 1'b0;
      fault_q     <= FAULT_NONE;
      margin_q    <= MARGIN_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid) begin
        margin_q <= cfg_i.data;
      end
      if (fire) begin
        phase_q <= phase_d;
        cross_q <= cross_d;
        off_q   <= off_d;
        fb_q    <= fb_d;
        power_q <= power_d;
        relay_q <= relay_d;
        fault_q <= fault_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      relay_on_q   <= relay_d;
      cycle_end_q  <= cyc_end;
      fault_code_q <= fault_d;
      fault_new_q  <= fresh;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.relay_on   = relay_on_q;
  assign rsp_o.cycle_end  = cycle_end_q;
  assign rsp_o.fault_code = fault_code_q;
  assign rsp_o.fault_new  = fault_new_q;
endmodule

`default_nettype wire

// ===== rtl/core/burst_fire_heater_supervisor.sv =====
// Top level of the burst-fire heater supervisor.
// Depends on bfhs_pkg, the three channel interfaces, bfhs_in_reg, bfhs_engine
// and burst_fire_heater_supervisor_macros.svh.
//
// Each request item is one event: a mains zero crossing, a relay feedback
// pulse, a supervision tick or a new power level. Every event yields exactly
// one result item with the relay drive, an end-of-period flag and the latched
// fault. The block takes one item per clock while the result channel is ready;
// each item passes the input register, then the state update that writes the
// result register; the counter and fault update paces it. Once a fault is
// latched, the relay stays open and every event is ignored until reset. The
// fault margin register is written via the always-ready configuration channel;
// the user must write it only while no item is in flight; it is not checked.
`default_nettype none

module burst_fire_heater_supervisor (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfhs_req_if.sink   req_i,
  bfhs_cfg_if.sink   cfg_i,
  bfhs_rsp_if.source rsp_o
);
  import bfhs_pkg::*;

  `include "burst_fire_heater_supervisor_macros.svh"

  hs_t  item_hs;
  req_t item;
  logic item_ready;

  bfhs_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_hs_o    (item_hs),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  bfhs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_hs.valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .cfg_i        (cfg_i),
    .rsp_o        (rsp_o)
  );

  `BFHS_ASSERT_SAME(a_relay_needs_no_fault, rsp_o.valid && rsp_o.relay_on, rsp_o.fault_code == FAULT_NONE)
  `BFHS_ASSERT_SAME(a_new_fault_code, rsp_o.valid && rsp_o.fault_new, rsp_o.fault_code != FAULT_NONE)
  `BFHS_ASSERT_NEXT(a_stalled_item_kept, item_hs.valid && !item_hs.ready, item_hs.valid)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the burst-fire heater supervisor.
// Predicts each result from its own model of the event counters and fault latch.
// Depends on bfhs_pkg, the three channel interfaces and burst_fire_heater_supervisor.

module tb_top;
  import bfhs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic   relay_on;
    logic   cycle_end;
    fault_e fault_code;
    logic   fault_new;
  } result_t;

  class heater_scoreboard;
    logic [7:0]  margin;
    logic [7:0]  phase;
    logic [7:0]  power_lvl;
    logic [15:0] crossings;
    logic [15:0] offs;
    logic [15:0] pulses;
    logic        relay;
    fault_e      fault;
    result_t     expected_q[$];
    int unsigned mismatches;

    function new();
      margin     = MARGIN_RESET;
      phase      = '0;
      power_lvl  = '0;
      crossings  = '0;
      offs       = '0;
      pulses     = '0;
      relay      = 1'b0;
      fault      = FAULT_NONE;
      mismatches = 0;
    endfunction

    function bit over_margin(logic [15:0] diff);
      return !diff[15] && (diff > {8'd0, margin});
    endfunction

    function bit tick_is_safe();
      return (crossings != 0) && !over_margin(offs - pulses) && !over_margin(pulses - offs);
    endfunction

    function void latch_fault(fault_e code);
      fault     = code;
      power_lvl = '0;
      relay     = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Steers the counters back toward a supervision tick that raises no fault.
    function req_t balancing_event();
      req_t ev;
      ev.power = 8'd0;
      if (crossings == 0) begin
        ev.req_type = REQ_CROSS;
      end else if (over_margin(offs - pulses)) begin
        ev.req_type = REQ_FEEDBACK;
      end else if (power_lvl != 0) begin
        ev.req_type = REQ_POWER;
      end else begin
        ev.req_type = REQ_CROSS;
      end
      return ev;
    endfunction

    function void note_event(req_t ev);
      result_t r;
      r = '{relay_on: 1'b0, cycle_end: 1'b0, fault_code: FAULT_NONE, fault_new: 1'b0};
      if (fault == FAULT_NONE) begin
        case (req_e'(ev.req_type))
          REQ_CROSS: begin
            crossings++;
            if (phase < power_lvl) begin
              relay = 1'b1;
            end else begin
              relay = 1'b0;
              offs++;
              if (phase >= MAX_POWER) begin
                phase       = '0;
                r.cycle_end = 1'b1;
              end
            end
            phase++;
          end
          REQ_FEEDBACK: pulses++;
          REQ_TICK: begin
            if (crossings == 0) begin
              latch_fault(FAULT_PHASE);
              r.fault_new = 1'b1;
            end else begin
              if (over_margin(offs - pulses)) begin
                latch_fault(FAULT_OPEN);
                r.fault_new = 1'b1;
              end else if (over_margin(pulses - offs)) begin
                latch_fault(FAULT_STUCK);
                r.fault_new = 1'b1;
              end
              crossings = '0;
              offs      = '0;
              pulses    = '0;
            end
          end
          default: begin
            if (ev.power <= MAX_POWER) power_lvl = ev.power;
          end
        endcase
      end
      r.relay_on   = relay;
      r.fault_code = fault;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic relay_on, logic cycle_end, logic [1:0] code,
                               logic fault_new);
      result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result error: unexpected item relay %0b end %0b fault %0d new %0b",
                   relay_on, cycle_end, code, fault_new);
        end
      end else begin
        exp = expected_q.pop_front();
        if (relay_on !== exp.relay_on || cycle_end !== exp.cycle_end ||
            code !== exp.fault_code || fault_new !== exp.fault_new) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result error: expected relay %0b end %0b fault %0d new %0b,",
                     exp.relay_on, exp.cycle_end, exp.fault_code, exp.fault_new,
                     " got relay %0b end %0b fault %0d new %0b",
                     relay_on, cycle_end, code, fault_new);
          end
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  bfhs_req_if req_if();
  bfhs_cfg_if cfg_if();
  bfhs_rsp_if rsp_if();

  burst_fire_heater_supervisor DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .cfg_i (cfg_if),
    .rsp_o (rsp_if)
  );

  heater_scoreboard sb = new();
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned idle_cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      sb.check_result(rsp_if.relay_on, rsp_if.cycle_end, rsp_if.fault_code, rsp_if.fault_new);
    end
    rsp_if.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic req_t make_event(req_e kind, logic [7:0] power);
    req_t ev;
    ev.req_type = kind;
    ev.power    = power;
    return ev;
  endfunction

  function automatic req_t random_event();
    int unsigned pick;
    req_t        ev;
    pick     = $urandom_range(0, 99);
    ev.power = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, MAX_POWER))
                                          : 8'($urandom_range(0, 255));
    if (pick < 50) begin
      ev.req_type = REQ_CROSS;
    end else if (pick < 72) begin
      ev.req_type = REQ_FEEDBACK;
    end else if (pick < 82) begin
      ev.req_type = REQ_TICK;
    end else begin
      ev.req_type = REQ_POWER;
    end
    return ev;
  endfunction

  task automatic set_traffic(int unsigned mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 68; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 68; end
      default: begin gap_pct = 6; stall_pct = 6; end
    endcase
  endtask

  task automatic send_event(req_t ev);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= ev.req_type;
    req_if.power    <= ev.power;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_event(ev);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_margin(logic [7:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    sb.margin = value;
  endtask

  task automatic safe_tick();
    while (!sb.tick_is_safe()) send_event(sb.balancing_event());
    send_event(make_event(REQ_TICK, 8'($urandom_range(0, 255))));
  endtask

  task automatic run_random(int unsigned count);
    req_t ev;
    repeat (count) begin
      ev = random_event();
      if (ev.req_type == REQ_TICK) begin
        safe_tick();
      end else begin
        send_event(ev);
      end
    end
  endtask

  // A fault latches until reset, so exactly one kind is provoked per run.
  task automatic provoke_fault();
    int unsigned kind;
    kind = $urandom_range(0, 2);
    safe_tick();
    case (kind)
      0: ;
      1: begin
        send_event(make_event(REQ_POWER, 8'd0));
        while (!sb.over_margin(sb.offs - sb.pulses)) send_event(make_event(REQ_CROSS, 8'd0));
      end
      default: begin
        send_event(make_event(REQ_CROSS, 8'd0));
        while (!sb.over_margin(sb.pulses - sb.offs)) begin
          send_event(make_event(REQ_FEEDBACK, 8'd0));
        end
      end
    endcase
    send_event(make_event(REQ_TICK, 8'd0));
    repeat (12) send_event(random_event());
  endtask

  initial begin
    logic [7:0] margins[8];
    margins = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(0, 255)), 8'd254,
                8'($urandom_range(0, 255)), MARGIN_RESET, 8'($urandom_range(0, 30))};
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_CROSS;
    req_if.power    = 8'd0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = 8'd0;
    rsp_if.ready    = 1'b0;
    idle_cycles     = 0;
    set_traffic(0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(make_event(REQ_POWER, 8'd0));
    send_event(make_event(REQ_CROSS, 8'd255));
    send_event(make_event(REQ_FEEDBACK, 8'hAA));
    send_event(make_event(REQ_POWER, 8'd255));
    send_event(make_event(REQ_POWER, MAX_POWER + 8'd1));
    send_event(make_event(REQ_POWER, MAX_POWER));
    send_event(make_event(REQ_CROSS, 8'h55));
    send_event(make_event(REQ_TICK, 8'd255));
    send_event(make_event(REQ_POWER, 8'd1));
    send_event(make_event(REQ_CROSS, 8'd0));
    send_event(make_event(REQ_FEEDBACK, 8'd0));
    send_event(make_event(REQ_TICK, 8'd0));

    for (int i = 0; i < 8; i++) begin
      wait_drained();
      write_margin(margins[i]);
      set_traffic(i % 4);
      run_random(165);
    end

    wait_drained();
    write_margin(8'($urandom_range(0, 255)));
    set_traffic($urandom_range(0, 3));
    provoke_fault();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
